// ===== src/pri_pkg.sv =====
// Shared widths and constants of the PageRank power iteration block.
package pri_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int VIDX_W       = $clog2(MAX_VERTICES);
    localparam int NCNT_W       = $clog2(MAX_VERTICES + 1);
    localparam int RANK_W       = 32;
    localparam int DEG_W        = 16;
    localparam int ROW_W        = MAX_VERTICES + DEG_W;
    localparam int DIV_W        = 33;
    localparam int OTHER_W      = 33;
    localparam int EDGE_W       = 34;
    localparam int WGT_W        = EDGE_W + OTHER_W;
    localparam int ACC_W        = 41;
    localparam int REM_W        = DEG_W;
    localparam int DCNT_W       = $clog2(DIV_W + 1);

    localparam logic [1:0] KIND_EDGE  = 2'd0;
    localparam logic [1:0] KIND_RUN   = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    localparam logic [1:0] CFG_VCOUNT = 2'd0;
    localparam logic [1:0] CFG_ITERS  = 2'd1;
    localparam logic [1:0] CFG_WEIGHT = 2'd2;

    localparam logic [6:0]  VCOUNT_RST = 7'd64;
    localparam logic [7:0]  ITERS_RST  = 8'd20;
    localparam logic [15:0] WEIGHT_RST = 16'd55706;

endpackage

// ===== src/pagerank_power_iteration_top.sv =====
// PageRank power iteration engine: graph store, weight setup, iteration and rank output.
//
// Usage. Requests arrive on the input channel (in_valid / in_stall) with a kind and two
// vertex indexes. An edge request sets one bit of the adjacency matrix and bumps the
// source's out-degree; it reads the graph row, then writes it back. A clear request empties
// the graph through per-row valid flags. A run request computes ranks and then sends one
// result per vertex on the output channel (out_valid / out_stall), in index order, with
// last_rank set on the final vertex. A run does weight setup (a bit-serial divider produces
// the teleport term, 1/N and a link term per column whose out-degree is neither zero nor N),
// then power iteration, where the rank and weight memories are read once per matrix element,
// and then sends the results. in_stall is high for the whole of a run and drops once the
// last result sits in the output register, so the next request can be taken while it waits.
// A stalled output holds the result register and pauses the output sequencer. Configuration
// writes (cfg_valid / cfg_ready) are always ready; the user makes them only while idle, as
// the block does not enforce this. Reset empties the graph, restores the register defaults
// and leaves the block idle; the rank memories need no clearing since every run writes them
// before reading them.
module pagerank_power_iteration_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [5:0]  source_vertex,
    input  logic [5:0]  dest_vertex,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [5:0]  vertex_index,
    output logic [31:0] rank_value,
    output logic        last_rank,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    typedef enum logic [10:0] {
        ST_IDLE   = 11'b000_0000_0001,
        ST_EDGE   = 11'b000_0000_0010,
        ST_TELE   = 11'b000_0000_0100,
        ST_UNI    = 11'b000_0000_1000,
        ST_COLRD  = 11'b000_0001_0000,
        ST_COLEV  = 11'b000_0010_0000,
        ST_COLDIV = 11'b000_0100_0000,
        ST_ROW    = 11'b000_1000_0000,
        ST_DRAIN  = 11'b001_0000_0000,
        ST_EMRD   = 11'b010_0000_0000,
        ST_EMLD   = 11'b100_0000_0000
    } state_t;

    localparam int VW = pri_pkg::VIDX_W;
    localparam int NW = pri_pkg::NCNT_W;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [6:0]  vcount_reg, vcount_next;
    logic [7:0]  iters_reg, iters_next;
    logic [15:0] weight_reg, weight_next;

    // Run control.
    logic [NW-1:0] n_reg, n_next;
    logic [VW-1:0] j_reg, j_next;
    logic [VW-1:0] i_reg, i_next;
    logic [VW-1:0] iss_reg, iss_next;
    logic [VW-1:0] e_reg, e_next;
    logic [7:0]    it_reg, it_next;
    logic          sel_reg, sel_next;
    logic          v1_reg, v1_next;
    logic          v2_reg, v2_next;
    logic [pri_pkg::ACC_W-1:0] acc_reg, acc_next;
    logic [31:0]   tele_reg, tele_next;
    logic [pri_pkg::DIV_W-1:0] uni_reg, uni_next;
    logic [VW-1:0] src_reg, src_next;
    logic [VW-1:0] dst_reg, dst_next;

    // Graph row valid flags stand for the reset and clear value of the graph memory.
    logic [pri_pkg::MAX_VERTICES-1:0] gval_reg, gval_next;
    logic gvq_reg, gvq_next;

    // Multiplier stage.
    logic [31:0]              plo_reg, plo_next;
    logic [pri_pkg::EDGE_W-1:0] phi_reg, phi_next;

    // Output register.
    logic        ov_reg, ov_next;
    logic [5:0]  oidx_reg, oidx_next;
    logic [31:0] orank_reg, orank_next;
    logic        olast_reg, olast_next;

    // Memories and divider.
    logic                       g_we;
    logic [VW-1:0]              g_waddr, g_raddr;
    logic [pri_pkg::ROW_W-1:0]  g_wdata, g_rdata;
    logic                       w_we;
    logic [pri_pkg::WGT_W-1:0]  w_wdata, w_rdata;
    logic                       ra_we, rb_we;
    logic [VW-1:0]              r_waddr, r_raddr;
    logic [31:0]                r_wdata, ra_rdata, rb_rdata;
    logic                       wr_cur, wr_oth;
    logic                       div_start, div_done;
    logic [pri_pkg::DIV_W-1:0]  div_dividend, div_quo;
    logic [pri_pkg::DEG_W-1:0]  div_divisor;

    logic [pri_pkg::MAX_VERTICES-1:0] row_eff;
    logic [pri_pkg::DEG_W-1:0]  deg;
    logic [NW-1:0]              n_m1, n_clamp;
    logic                       col_last;
    logic [31:0]                start_rank, cur_rank, sat_acc;
    logic [pri_pkg::EDGE_W-1:0] wsel;
    logic [63:0]                lo_full;
    logic                       out_take, in_take;

    pri_ram #(.WIDTH(pri_pkg::ROW_W), .DEPTH(pri_pkg::MAX_VERTICES)) u_graph (
        .clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
        .raddr(g_raddr), .rdata(g_rdata)
    );

    pri_ram #(.WIDTH(pri_pkg::WGT_W), .DEPTH(pri_pkg::MAX_VERTICES)) u_weight (
        .clk(clk), .we(w_we), .waddr(j_reg), .wdata(w_wdata),
        .raddr(iss_reg), .rdata(w_rdata)
    );

    pri_ram #(.WIDTH(pri_pkg::RANK_W), .DEPTH(pri_pkg::MAX_VERTICES)) u_rank_a (
        .clk(clk), .we(ra_we), .waddr(r_waddr), .wdata(r_wdata),
        .raddr(r_raddr), .rdata(ra_rdata)
    );

    pri_ram #(.WIDTH(pri_pkg::RANK_W), .DEPTH(pri_pkg::MAX_VERTICES)) u_rank_b (
        .clk(clk), .we(rb_we), .waddr(r_waddr), .wdata(r_wdata),
        .raddr(r_raddr), .rdata(rb_rdata)
    );

    pri_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dividend),
        .divisor(div_divisor), .done(div_done), .quotient(div_quo)
    );

    // Rows that were never written since reset or a clear read as empty.
    assign row_eff    = gvq_reg ? g_rdata[pri_pkg::MAX_VERTICES-1:0] : '0;
    assign deg        = gvq_reg ? g_rdata[pri_pkg::ROW_W-1:pri_pkg::MAX_VERTICES] : '0;
    assign n_m1       = n_reg - 1'b1;
    assign col_last   = {1'b0, j_reg} == n_m1;
    assign start_rank = uni_reg[pri_pkg::DIV_W-1] ? '1 : uni_reg[31:0];
    assign cur_rank   = sel_reg ? rb_rdata : ra_rdata;
    assign sat_acc    = (acc_reg[pri_pkg::ACC_W-1:32] != '0) ? '1 : acc_reg[31:0];
    assign out_take   = ov_reg && !out_stall;
    assign in_take    = in_valid && (state_reg == ST_IDLE);

    // A vertex count of zero acts as one, and anything above the maximum as the maximum.
    assign n_clamp = (vcount_reg == '0) ? NW'(1) :
                     (vcount_reg > 7'(pri_pkg::MAX_VERTICES)) ? NW'(pri_pkg::MAX_VERTICES) :
                     NW'(vcount_reg);

    // Column weight chosen by the adjacency bit, then the split product against the rank.
    assign wsel    = row_eff[i_reg] ? w_rdata[pri_pkg::WGT_W-1:pri_pkg::OTHER_W]
                                    : pri_pkg::EDGE_W'(w_rdata[pri_pkg::OTHER_W-1:0]);
    assign lo_full = 64'(wsel[31:0]) * 64'(cur_rank);

    always_comb
    begin
        g_raddr = j_reg;
        if (state_reg == ST_IDLE)
        begin
            g_raddr = source_vertex;
        end
        else if (state_reg == ST_ROW)
        begin
            g_raddr = iss_reg;
        end
        r_raddr = (state_reg == ST_ROW) ? iss_reg : e_reg;
    end

    always_comb
    begin
        state_next  = state_reg;
        vcount_next = vcount_reg;
        iters_next  = iters_reg;
        weight_next = weight_reg;
        n_next      = n_reg;
        j_next      = j_reg;
        i_next      = i_reg;
        iss_next    = iss_reg;
        e_next      = e_reg;
        it_next     = it_reg;
        sel_next    = sel_reg;
        v1_next     = 1'b0;
        v2_next     = v1_reg;
        acc_next    = acc_reg;
        tele_next   = tele_reg;
        uni_next    = uni_reg;
        src_next    = src_reg;
        dst_next    = dst_reg;
        gval_next   = gval_reg;
        gvq_next    = gval_reg[g_raddr];
        plo_next    = lo_full[63:32];
        phi_next    = pri_pkg::EDGE_W'(wsel[pri_pkg::EDGE_W-1:32]) *
                      pri_pkg::EDGE_W'(cur_rank);
        ov_next     = out_take ? 1'b0 : ov_reg;
        oidx_next   = oidx_reg;
        orank_next  = orank_reg;
        olast_next  = olast_reg;

        g_we         = 1'b0;
        g_waddr      = src_reg;
        g_wdata      = {(deg == '1) ? deg : deg + 1'b1,
                        row_eff | (pri_pkg::MAX_VERTICES'(1) << dst_reg)};
        w_we         = 1'b0;
        w_wdata      = {pri_pkg::EDGE_W'(uni_reg), uni_reg};
        wr_cur       = 1'b0;
        wr_oth       = 1'b0;
        div_start    = 1'b0;
        div_dividend = {1'b0, weight_reg, 16'd0};
        div_divisor  = pri_pkg::DEG_W'(n_reg);

        if (v2_reg)
        begin
            acc_next = acc_reg + pri_pkg::ACC_W'(phi_reg) + pri_pkg::ACC_W'(plo_reg);
        end

        if (cfg_valid)
        begin
            case (cfg_index)
                pri_pkg::CFG_VCOUNT: vcount_next = cfg_data[6:0];
                pri_pkg::CFG_ITERS:  iters_next  = cfg_data[7:0];
                pri_pkg::CFG_WEIGHT: weight_next = cfg_data;
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    case (kind)
                        pri_pkg::KIND_EDGE:
                        begin
                            src_next   = source_vertex;
                            dst_next   = dest_vertex;
                            state_next = ST_EDGE;
                        end
                        pri_pkg::KIND_RUN:
                        begin
                            n_next       = n_clamp;
                            div_start    = 1'b1;
                            div_divisor  = pri_pkg::DEG_W'(n_clamp);
                            state_next   = ST_TELE;
                        end
                        pri_pkg::KIND_CLEAR:
                        begin
                            gval_next = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_EDGE:
            begin
                g_we              = 1'b1;
                gval_next[src_reg] = 1'b1;
                state_next        = ST_IDLE;
            end
            ST_TELE:
            begin
                if (div_done)
                begin
                    tele_next    = div_quo[31:0];
                    div_start    = 1'b1;
                    div_dividend = pri_pkg::DIV_W'(1) << 32;
                    state_next   = ST_UNI;
                end
            end
            ST_UNI:
            begin
                if (div_done)
                begin
                    uni_next   = div_quo;
                    j_next     = '0;
                    state_next = ST_COLRD;
                end
            end
            ST_COLRD:
            begin
                state_next = ST_COLEV;
            end
            ST_COLEV, ST_COLDIV:
            begin
                if (state_reg == ST_COLEV)
                begin
                    wr_cur = 1'b1;
                    if (deg == '0 || deg == pri_pkg::DEG_W'(n_reg))
                    begin
                        w_we = 1'b1;
                    end
                    else
                    begin
                        div_start    = 1'b1;
                        div_dividend = {17'h1_0000 - {1'b0, weight_reg}, 16'd0};
                        div_divisor  = deg;
                        state_next   = ST_COLDIV;
                    end
                end
                else if (div_done)
                begin
                    w_we    = 1'b1;
                    w_wdata = {pri_pkg::EDGE_W'(div_quo) + pri_pkg::EDGE_W'(tele_reg),
                               pri_pkg::OTHER_W'(tele_reg)};
                end
                if (w_we)
                begin
                    if (col_last)
                    begin
                        e_next   = '0;
                        it_next  = '0;
                        i_next   = '0;
                        iss_next = '0;
                        state_next = (iters_reg == '0) ? ST_EMRD : ST_ROW;
                    end
                    else
                    begin
                        j_next     = j_reg + 1'b1;
                        state_next = ST_COLRD;
                    end
                end
            end
            ST_ROW:
            begin
                v1_next = 1'b1;
                if ({1'b0, iss_reg} == n_m1)
                begin
                    iss_next   = '0;
                    state_next = ST_DRAIN;
                end
                else
                begin
                    iss_next = iss_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (!v1_reg && !v2_reg)
                begin
                    wr_oth   = 1'b1;
                    acc_next = '0;
                    state_next = ST_ROW;
                    if ({1'b0, i_reg} == n_m1)
                    begin
                        i_next   = '0;
                        sel_next = !sel_reg;
                        if ({1'b0, it_reg} + 9'd1 == {1'b0, iters_reg})
                        begin
                            e_next     = '0;
                            state_next = ST_EMRD;
                        end
                        else
                        begin
                            it_next = it_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        i_next = i_reg + 1'b1;
                    end
                end
            end
            ST_EMRD:
            begin
                state_next = ST_EMLD;
            end
            ST_EMLD:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next    = 1'b1;
                    oidx_next  = e_reg;
                    orank_next = cur_rank;
                    olast_next = {1'b0, e_reg} == n_m1;
                    if ({1'b0, e_reg} == n_m1)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        e_next     = e_reg + 1'b1;
                        state_next = ST_EMRD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Setup writes the start ranks into the current bank; each row sum goes to the other one.
    assign r_waddr = wr_cur ? j_reg : i_reg;
    assign r_wdata = wr_cur ? start_rank : sat_acc;
    assign ra_we   = (wr_cur && !sel_reg) || (wr_oth && sel_reg);
    assign rb_we   = (wr_cur && sel_reg) || (wr_oth && !sel_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            vcount_reg <= pri_pkg::VCOUNT_RST;
            iters_reg  <= pri_pkg::ITERS_RST;
            weight_reg <= pri_pkg::WEIGHT_RST;
            gval_reg   <= '0;
            gvq_reg    <= 1'b0;
            ov_reg     <= 1'b0;
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            sel_reg    <= 1'b0;
            n_reg      <= '0;
            j_reg      <= '0;
            i_reg      <= '0;
            iss_reg    <= '0;
            e_reg      <= '0;
            it_reg     <= '0;
            acc_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            vcount_reg <= vcount_next;
            iters_reg  <= iters_next;
            weight_reg <= weight_next;
            gval_reg   <= gval_next;
            gvq_reg    <= gvq_next;
            ov_reg     <= ov_next;
            v1_reg     <= v1_next;
            v2_reg     <= v2_next;
            sel_reg    <= sel_next;
            n_reg      <= n_next;
            j_reg      <= j_next;
            i_reg      <= i_next;
            iss_reg    <= iss_next;
            e_reg      <= e_next;
            it_reg     <= it_next;
            acc_reg    <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tele_reg  <= tele_next;
        uni_reg   <= uni_next;
        src_reg   <= src_next;
        dst_reg   <= dst_next;
        plo_reg   <= plo_next;
        phi_reg   <= phi_next;
        oidx_reg  <= oidx_next;
        orank_reg <= orank_next;
        olast_reg <= olast_next;
    end

    assign in_stall     = state_reg != ST_IDLE;
    assign cfg_ready    = 1'b1;
    assign out_valid    = ov_reg;
    assign vertex_index = oidx_reg;
    assign rank_value   = orank_reg;
    assign last_rank    = olast_reg;

endmodule

// ===== src/pri_ram.sv =====
// Generic simple dual-port RAM with a registered read.
module pri_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/pri_div.sv =====
// Restoring divider that retires one quotient bit per cycle.
module pri_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [pri_pkg::DIV_W-1:0] dividend,
    input  logic [pri_pkg::DEG_W-1:0] divisor,
    output logic                      done,
    output logic [pri_pkg::DIV_W-1:0] quotient
);

    logic [pri_pkg::DIV_W-1:0]  quo_reg, quo_next;
    logic [pri_pkg::REM_W-1:0]  rem_reg, rem_next;
    logic [pri_pkg::DEG_W-1:0]  dvs_reg, dvs_next;
    logic [pri_pkg::DCNT_W-1:0] cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [pri_pkg::REM_W:0]    shifted;
    logic                       fits;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, quo_reg[pri_pkg::DIV_W-1]};
        fits      = shifted >= {1'b0, dvs_reg};
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = pri_pkg::DCNT_W'(pri_pkg::DIV_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next = pri_pkg::REM_W'(shifted - {1'b0, dvs_reg});
            end
            else
            begin
                rem_next = shifted[pri_pkg::REM_W-1:0];
            end
            quo_next = {quo_reg[pri_pkg::DIV_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == pri_pkg::DCNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
